// File: sv/rrs_pkg.sv
package rrs_pkg;

  // coordinate and field widths
  localparam int COORD_WIDTH = 15;
  localparam int OUT_WIDTH   = 16;
  localparam int DIM_WIDTH   = 13;
  localparam int RAD_WIDTH   = 12;

  // internal signed width, wide enough for box_y + box_height and bx + w exactly
  localparam int SUM_WIDTH = ((COORD_WIDTH > DIM_WIDTH + 1) ? COORD_WIDTH : DIM_WIDTH + 1) + 2;

  // square root operand: r*r - dy*dy stays below 2^(2*RAD_WIDTH)
  localparam int Q_WIDTH        = 2 * RAD_WIDTH;
  localparam int REM_WIDTH      = RAD_WIDTH + 3;
  localparam int ITER_PER_STAGE = 2;
  localparam int SQRT_STAGES    = RAD_WIDTH / ITER_PER_STAGE;

  // pipeline layout
  localparam int ST_CORNER     = 1;
  localparam int ST_PRODUCT    = 2;
  localparam int ST_SQRT_FIRST = 3;
  localparam int ST_SQRT_LAST  = ST_SQRT_FIRST + SQRT_STAGES - 1;
  localparam int PIPE_DEPTH    = ST_SQRT_LAST + 1;
  localparam int NUM_STAGES    = PIPE_DEPTH + 1;

  // configuration port
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 32;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_BOX_X      = 3'd0,
    CFG_BOX_Y      = 3'd1,
    CFG_BOX_WIDTH  = 3'd2,
    CFG_BOX_HEIGHT = 3'd3,
    CFG_RAD_TL     = 3'd4,
    CFG_RAD_TR     = 3'd5,
    CFG_RAD_BR     = 3'd6,
    CFG_RAD_BL     = 3'd7
  } cfg_idx_e;

  // corner order in the radius array
  localparam int CORNER_TL = 0;
  localparam int CORNER_TR = 1;
  localparam int CORNER_BR = 2;
  localparam int CORNER_BL = 3;

  // digit-by-digit square root state
  typedef struct packed {
    logic [Q_WIDTH-1:0]   q;
    logic [REM_WIDTH-1:0] rem;
    logic [RAD_WIDTH-1:0] root;
  } sqrt_t;

  // payload carried down the pipeline
  typedef struct packed {
    logic                          inbox;
    logic [DIM_WIDTH-1:0]          ly;
    logic [3:0][RAD_WIDTH-1:0]     rad;
    logic [RAD_WIDTH-1:0]          rl;
    logic [RAD_WIDTH-1:0]          rr;
    logic [RAD_WIDTH-1:0]          dl;
    logic [RAD_WIDTH-1:0]          dr;
    sqrt_t                         sl;
    sqrt_t                         sr;
  } pipe_t;

  // one restoring square root iteration, two operand bits in, one root bit out
  function automatic sqrt_t isqrt_step(sqrt_t s);
    logic [REM_WIDTH-1:0] acc;
    logic [REM_WIDTH-1:0] trial;
    sqrt_t                n;
    acc   = {s.rem[REM_WIDTH-3:0], s.q[Q_WIDTH-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    n.q   = {s.q[Q_WIDTH-3:0], 2'b00};
    if (acc >= trial) begin
      n.rem  = acc - trial;
      n.root = {s.root[RAD_WIDTH-2:0], 1'b1};
    end else begin
      n.rem  = acc;
      n.root = {s.root[RAD_WIDTH-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

// File: sv/rrs_if.sv
// scanline row request
interface rrs_row_if import rrs_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] row_y;

  modport source (output valid, output row_y, input ready);
  modport sink   (input valid, input row_y, output ready);
endinterface

// covered span result
interface rrs_span_if import rrs_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        span_valid;
  logic signed [OUT_WIDTH-1:0] span_left;
  logic signed [OUT_WIDTH-1:0] span_right;

  modport source (output valid, output span_valid, output span_left, output span_right,
                  input ready);
  modport sink   (input valid, input span_valid, input span_left, input span_right,
                  output ready);
endinterface

// register write channel
interface rrs_cfg_if import rrs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_IDX_WIDTH-1:0]  index;
  logic [CFG_DATA_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/rounded_rect_scanline_span_top.sv
// channel  | dir | transaction payload
// ---------+-----+-------------------------------------------------
// cfg_i    | in  | index (register 0..7), data (low bits kept)
// row_i    | in  | row_y, signed scanline row
// span_o   | out | span_valid, span_left, span_right
//
// one row per cycle sustained while span_o is not stalled; each taken row passes through
// (row/box compare, corner select, product, six stages of two square root steps, output)
// the square root pipeline of two root bits per stage sets the latency
// rst_ni clears the registers and all stage valid bits; payload registers are not reset
// a stall holds each stage that is full and whose successor cannot take it; bubbles close up
// register writes are always accepted and must only arrive while the pipeline is empty
module rounded_rect_scanline_span_top import rrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rrs_cfg_if.sink     cfg_i,
  rrs_row_if.sink     row_i,
  rrs_span_if.source  span_o
);

  // configuration registers
  logic signed [COORD_WIDTH-1:0] box_x_q;
  logic signed [COORD_WIDTH-1:0] box_y_q;
  logic [DIM_WIDTH-1:0]          box_w_q;
  logic [DIM_WIDTH-1:0]          box_h_q;
  logic [3:0][RAD_WIDTH-1:0]     rad_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q <= '0;
      box_y_q <= '0;
      box_w_q <= '0;
      box_h_q <= '0;
      rad_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_BOX_X:      box_x_q <= cfg_i.data[COORD_WIDTH-1:0];
        CFG_BOX_Y:      box_y_q <= cfg_i.data[COORD_WIDTH-1:0];
        CFG_BOX_WIDTH:  box_w_q <= cfg_i.data[DIM_WIDTH-1:0];
        CFG_BOX_HEIGHT: box_h_q <= cfg_i.data[DIM_WIDTH-1:0];
        CFG_RAD_TL:     rad_q[CORNER_TL] <= cfg_i.data[RAD_WIDTH-1:0];
        CFG_RAD_TR:     rad_q[CORNER_TR] <= cfg_i.data[RAD_WIDTH-1:0];
        CFG_RAD_BR:     rad_q[CORNER_BR] <= cfg_i.data[RAD_WIDTH-1:0];
        CFG_RAD_BL:     rad_q[CORNER_BL] <= cfg_i.data[RAD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and advance chain
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || span_o.ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign row_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= row_i.valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (adv[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // sign-extended box origin
  logic signed [SUM_WIDTH-1:0] bx_ext;
  logic signed [SUM_WIDTH-1:0] by_ext;

  assign bx_ext = {{(SUM_WIDTH-COORD_WIDTH){box_x_q[COORD_WIDTH-1]}}, box_x_q};
  assign by_ext = {{(SUM_WIDTH-COORD_WIDTH){box_y_q[COORD_WIDTH-1]}}, box_y_q};

  // pipeline payload
  pipe_t pipe_q [PIPE_DEPTH];
  pipe_t pipe_d [PIPE_DEPTH];

  // first stage: row against box, radius clamp
  logic signed [SUM_WIDTH-1:0] row_ext;
  logic signed [SUM_WIDTH-1:0] ly_full;
  logic [DIM_WIDTH-1:0]        min_wh;
  logic [RAD_WIDTH-1:0]        lim;

  assign row_ext = {{(SUM_WIDTH-COORD_WIDTH){row_i.row_y[COORD_WIDTH-1]}}, row_i.row_y};
  assign ly_full = row_ext - by_ext;
  assign min_wh  = (box_w_q < box_h_q) ? box_w_q : box_h_q;
  assign lim     = min_wh[DIM_WIDTH-1:1];

  always_comb begin
    pipe_d[0]       = '0;
    pipe_d[0].inbox = (box_w_q != '0) && (box_h_q != '0) && !ly_full[SUM_WIDTH-1]
                      && (ly_full < SUM_WIDTH'(box_h_q));
    pipe_d[0].ly    = ly_full[DIM_WIDTH-1:0];
    for (int c = 0; c < 4; c++) begin
      pipe_d[0].rad[c] = (rad_q[c] > lim) ? lim : rad_q[c];
    end
  end

  // corner band select: at most one corner per side touches a row
  logic                 top_l, bot_l, top_r, bot_r;
  logic [DIM_WIDTH-1:0] from_bot;

  always_comb begin
    pipe_d[ST_CORNER] = pipe_q[ST_CORNER-1];
    from_bot = box_h_q - DIM_WIDTH'(1) - pipe_q[ST_CORNER-1].ly;
    top_l = pipe_q[ST_CORNER-1].ly < DIM_WIDTH'(pipe_q[ST_CORNER-1].rad[CORNER_TL]);
    bot_l = pipe_q[ST_CORNER-1].ly
            >= (box_h_q - DIM_WIDTH'(pipe_q[ST_CORNER-1].rad[CORNER_BL]));
    top_r = pipe_q[ST_CORNER-1].ly < DIM_WIDTH'(pipe_q[ST_CORNER-1].rad[CORNER_TR]);
    bot_r = pipe_q[ST_CORNER-1].ly
            >= (box_h_q - DIM_WIDTH'(pipe_q[ST_CORNER-1].rad[CORNER_BR]));
    if (top_l) begin
      pipe_d[ST_CORNER].rl = pipe_q[ST_CORNER-1].rad[CORNER_TL];
      pipe_d[ST_CORNER].dl = pipe_q[ST_CORNER-1].ly[RAD_WIDTH-1:0];
    end else if (bot_l) begin
      pipe_d[ST_CORNER].rl = pipe_q[ST_CORNER-1].rad[CORNER_BL];
      pipe_d[ST_CORNER].dl = from_bot[RAD_WIDTH-1:0];
    end else begin
      pipe_d[ST_CORNER].rl = '0;
      pipe_d[ST_CORNER].dl = '0;
    end
    if (top_r) begin
      pipe_d[ST_CORNER].rr = pipe_q[ST_CORNER-1].rad[CORNER_TR];
      pipe_d[ST_CORNER].dr = pipe_q[ST_CORNER-1].ly[RAD_WIDTH-1:0];
    end else if (bot_r) begin
      pipe_d[ST_CORNER].rr = pipe_q[ST_CORNER-1].rad[CORNER_BR];
      pipe_d[ST_CORNER].dr = from_bot[RAD_WIDTH-1:0];
    end else begin
      pipe_d[ST_CORNER].rr = '0;
      pipe_d[ST_CORNER].dr = '0;
    end
  end

  // r*r - dy*dy written as (d+1)*(2r-1-d)
  logic [DIM_WIDTH-1:0]   fa_l, fb_l, fa_r, fb_r;
  logic [2*DIM_WIDTH-1:0] prod_l, prod_r;

  always_comb begin
    pipe_d[ST_PRODUCT] = pipe_q[ST_PRODUCT-1];
    fa_l   = {1'b0, pipe_q[ST_PRODUCT-1].dl} + DIM_WIDTH'(1);
    fb_l   = {pipe_q[ST_PRODUCT-1].rl, 1'b0} - DIM_WIDTH'(1) - {1'b0, pipe_q[ST_PRODUCT-1].dl};
    fa_r   = {1'b0, pipe_q[ST_PRODUCT-1].dr} + DIM_WIDTH'(1);
    fb_r   = {pipe_q[ST_PRODUCT-1].rr, 1'b0} - DIM_WIDTH'(1) - {1'b0, pipe_q[ST_PRODUCT-1].dr};
    prod_l = fa_l * fb_l;
    prod_r = fa_r * fb_r;
    pipe_d[ST_PRODUCT].sl.rem  = '0;
    pipe_d[ST_PRODUCT].sl.root = '0;
    pipe_d[ST_PRODUCT].sr.rem  = '0;
    pipe_d[ST_PRODUCT].sr.root = '0;
    pipe_d[ST_PRODUCT].sl.q = (pipe_q[ST_PRODUCT-1].rl != '0) ? prod_l[Q_WIDTH-1:0] : '0;
    pipe_d[ST_PRODUCT].sr.q = (pipe_q[ST_PRODUCT-1].rr != '0) ? prod_r[Q_WIDTH-1:0] : '0;
  end

  // square root stages, two root bits each, both sides in parallel
  for (genvar s = ST_SQRT_FIRST; s <= ST_SQRT_LAST; s++) begin : g_sqrt
    always_comb begin
      pipe_d[s] = pipe_q[s-1];
      for (int k = 0; k < ITER_PER_STAGE; k++) begin
        pipe_d[s].sl = isqrt_step(pipe_d[s].sl);
        pipe_d[s].sr = isqrt_step(pipe_d[s].sr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PIPE_DEPTH; i++) begin
      if (adv[i]) pipe_q[i] <= pipe_d[i];
    end
  end

  // output stage: apply insets and check for an empty span
  logic [RAD_WIDTH-1:0]        inset_l, inset_r;
  logic signed [SUM_WIDTH-1:0] left_w, right_w;
  logic                        ok;

  assign inset_l = pipe_q[ST_SQRT_LAST].rl - pipe_q[ST_SQRT_LAST].sl.root;
  assign inset_r = pipe_q[ST_SQRT_LAST].rr - pipe_q[ST_SQRT_LAST].sr.root;
  assign left_w  = bx_ext + SUM_WIDTH'(inset_l);
  assign right_w = bx_ext + SUM_WIDTH'(box_w_q) - SUM_WIDTH'(inset_r);
  assign ok      = pipe_q[ST_SQRT_LAST].inbox && (right_w > left_w);

  logic                        span_valid_q;
  logic signed [OUT_WIDTH-1:0] span_left_q, span_right_q;

  always_ff @(posedge clk_i) begin
    if (adv[NUM_STAGES-1]) begin
      span_valid_q <= ok;
      span_left_q  <= ok ? left_w[OUT_WIDTH-1:0] : '0;
      span_right_q <= ok ? right_w[OUT_WIDTH-1:0] : '0;
    end
  end

  assign span_o.valid      = vld_q[NUM_STAGES-1];
  assign span_o.span_valid = span_valid_q;
  assign span_o.span_left  = span_left_q;
  assign span_o.span_right = span_right_q;

  // checks
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_o.valid && span_o.span_valid |-> span_o.span_left < span_o.span_right)
    else $error("covered span is empty or reversed");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_o.valid && !span_o.span_valid |-> span_o.span_left == '0 && span_o.span_right == '0)
    else $error("invalid span carries nonzero bounds");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !row_i.ready |-> span_o.valid && !span_o.ready && (&vld_q))
    else $error("row input blocked without a full stalled pipeline");

  // rows outside the box carry meaningless corner data, so only rows inside are checked
  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_SQRT_LAST] && pipe_q[ST_SQRT_LAST].inbox
      |-> pipe_q[ST_SQRT_LAST].sl.root <= pipe_q[ST_SQRT_LAST].rl
          && pipe_q[ST_SQRT_LAST].sr.root <= pipe_q[ST_SQRT_LAST].rr)
    else $error("corner square root exceeds its radius");

endmodule

// File: dv/tb.sv
module tb;
  import rrs_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int RESET_CYCLES   = 6;
  localparam int DRAIN_CYCLES   = 2 * NUM_STAGES + 4;
  localparam int RANDOM_PHASES  = 20;
  localparam int ROWS_PER_PHASE = 56;
  localparam int PRINT_LIMIT    = 100;

  localparam longint COORD_MIN = -(longint'(1) << (COORD_WIDTH - 1));
  localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
  localparam longint DIM_MAX   = (longint'(1) << DIM_WIDTH) - 1;
  localparam longint RAD_MAX   = (longint'(1) << RAD_WIDTH) - 1;

  // box geometry as held in the register file
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] box_x;
    logic signed [COORD_WIDTH-1:0] box_y;
    logic [DIM_WIDTH-1:0]          width;
    logic [DIM_WIDTH-1:0]          height;
    logic [3:0][RAD_WIDTH-1:0]     rad;
  } box_cfg_t;

  // one covered span
  typedef struct packed {
    logic                        covered;
    logic signed [OUT_WIDTH-1:0] left_x;
    logic signed [OUT_WIDTH-1:0] right_x;
  } span_t;

  logic clk = 1'b0;
  logic rst_n;

  rrs_cfg_if  cfg_if ();
  rrs_row_if  row_if ();
  rrs_span_if span_if ();

  box_cfg_t                      box_regs = '0;
  span_t                         span_q[$];
  logic signed [COORD_WIDTH-1:0] row_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int rows_offered   = 0;
  int rows_taken     = 0;
  int spans_seen     = 0;
  int spans_covered  = 0;
  int mismatches     = 0;
  int cycles         = 0;
  int settings_used  = 0;

  rounded_rect_scanline_span_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .row_i  (row_if),
    .span_o (span_if)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // integer square root, one root bit per step from the top
  function automatic longint floor_root(longint n);
    longint root;
    longint trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // how far a corner of radius r pulls the edge in, d rows from the nearer edge row
  function automatic longint edge_pull(longint r, longint d);
    longint dy;
    longint q;
    if (r <= 0) return 0;
    dy = r - 1 - d;
    q  = r * r - dy * dy;
    if (q < 0) q = 0;
    q = r - floor_root(q);
    return (q < 0) ? 0 : q;
  endfunction

  // span that the rounded box covers on one row
  function automatic span_t predict_span(logic signed [COORD_WIDTH-1:0] row, box_cfg_t c);
    longint bx, by, w, h, y, lim, ly, lo, hi, e;
    longint r[4];
    span_t  s;
    bx = longint'(signed'(c.box_x));
    by = longint'(signed'(c.box_y));
    w  = longint'(c.width);
    h  = longint'(c.height);
    y  = longint'(row);
    s  = '0;
    if (w == 0 || h == 0) return s;
    if (y < by || y >= by + h) return s;
    // radii clamped to half the smaller side
    lim = ((w < h) ? w : h) / 2;
    for (int i = 0; i < 4; i++) begin
      r[i] = (longint'(c.rad[i]) > lim) ? lim : longint'(c.rad[i]);
    end
    ly = y - by;
    lo = bx;
    hi = bx + w;
    if (ly < r[CORNER_TL]) begin
      e = bx + edge_pull(r[CORNER_TL], ly);
      if (e > lo) lo = e;
    end
    if (ly >= h - r[CORNER_BL]) begin
      e = bx + edge_pull(r[CORNER_BL], h - 1 - ly);
      if (e > lo) lo = e;
    end
    if (ly < r[CORNER_TR]) begin
      e = bx + w - edge_pull(r[CORNER_TR], ly);
      if (e < hi) hi = e;
    end
    if (ly >= h - r[CORNER_BR]) begin
      e = bx + w - edge_pull(r[CORNER_BR], h - 1 - ly);
      if (e < hi) hi = e;
    end
    if (hi <= lo) return s;
    s.covered = 1'b1;
    s.left_x  = lo[OUT_WIDTH-1:0];
    s.right_x = hi[OUT_WIDTH-1:0];
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("[cycle %0d] span mismatch: %s", cycles, msg);
  endtask

  // scoreboard: predict on each row transaction, check on each span transaction
  always @(posedge clk) begin : scoreboard
    span_t got;
    span_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d spans outstanding", cycles, span_q.size());
      $display("TEST FAILED");
      $finish;
    end else if (rst_n) begin
      if (span_if.valid && span_if.ready) begin
        got.covered = span_if.span_valid;
        got.left_x  = span_if.span_left;
        got.right_x = span_if.span_right;
        spans_seen++;
        if (span_q.size() == 0) begin
          report_mismatch($sformatf("span %0d arrived with no row outstanding", spans_seen));
        end else begin
          want = span_q.pop_front();
          if (got.covered !== want.covered)
            report_mismatch($sformatf("span %0d span_valid got %0b want %0b",
                                      spans_seen, got.covered, want.covered));
          if (got.left_x !== want.left_x)
            report_mismatch($sformatf("span %0d span_left got %0d want %0d",
                                      spans_seen, got.left_x, want.left_x));
          if (got.right_x !== want.right_x)
            report_mismatch($sformatf("span %0d span_right got %0d want %0d",
                                      spans_seen, got.right_x, want.right_x));
        end
      end
      if (row_if.valid && row_if.ready) begin
        want = predict_span(row_if.row_y, box_regs);
        span_q.push_back(want);
        rows_taken++;
        if (want.covered) spans_covered++;
      end
      // register write, low bits kept
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_idx_e'(cfg_if.index))
          CFG_BOX_X:      box_regs.box_x             = cfg_if.data[COORD_WIDTH-1:0];
          CFG_BOX_Y:      box_regs.box_y             = cfg_if.data[COORD_WIDTH-1:0];
          CFG_BOX_WIDTH:  box_regs.width             = cfg_if.data[DIM_WIDTH-1:0];
          CFG_BOX_HEIGHT: box_regs.height            = cfg_if.data[DIM_WIDTH-1:0];
          CFG_RAD_TL:     box_regs.rad[CORNER_TL]    = cfg_if.data[RAD_WIDTH-1:0];
          CFG_RAD_TR:     box_regs.rad[CORNER_TR]    = cfg_if.data[RAD_WIDTH-1:0];
          CFG_RAD_BR:     box_regs.rad[CORNER_BR]    = cfg_if.data[RAD_WIDTH-1:0];
          CFG_RAD_BL:     box_regs.rad[CORNER_BL]    = cfg_if.data[RAD_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

  // row driver: an offered row is held until its transaction completes
  always @(negedge clk) begin
    if (!rst_n) begin
      row_if.valid <= 1'b0;
    end else if (!row_if.valid || rows_taken == rows_offered) begin
      if (row_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        row_if.row_y <= row_q.pop_front();
        row_if.valid <= 1'b1;
        rows_offered++;
      end else begin
        row_if.valid <= 1'b0;
      end
    end
  end

  // span receiver with random back-pressure
  always @(negedge clk) begin
    span_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_WIDTH-1:0] field,
                           input int width);
    logic [CFG_DATA_WIDTH-1:0] data;
    // junk in the upper bits half of the time
    data = ($urandom_range(1) == 1) ? CFG_DATA_WIDTH'($urandom()) : '0;
    for (int i = 0; i < width; i++) data[i] = field[i];
    @(negedge clk);
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_config(input box_cfg_t c);
    write_reg(CFG_BOX_X,      CFG_DATA_WIDTH'(c.box_x),          COORD_WIDTH);
    write_reg(CFG_BOX_Y,      CFG_DATA_WIDTH'(c.box_y),          COORD_WIDTH);
    write_reg(CFG_BOX_WIDTH,  CFG_DATA_WIDTH'(c.width),          DIM_WIDTH);
    write_reg(CFG_BOX_HEIGHT, CFG_DATA_WIDTH'(c.height),         DIM_WIDTH);
    write_reg(CFG_RAD_TL,     CFG_DATA_WIDTH'(c.rad[CORNER_TL]), RAD_WIDTH);
    write_reg(CFG_RAD_TR,     CFG_DATA_WIDTH'(c.rad[CORNER_TR]), RAD_WIDTH);
    write_reg(CFG_RAD_BR,     CFG_DATA_WIDTH'(c.rad[CORNER_BR]), RAD_WIDTH);
    write_reg(CFG_RAD_BL,     CFG_DATA_WIDTH'(c.rad[CORNER_BL]), RAD_WIDTH);
  endtask

  // rotate through the idling mixes, one per register setting
  task automatic begin_phase();
    case (settings_used % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
      default: begin send_idle_pct = 27; recv_stall_pct = 27; end
    endcase
    settings_used++;
  endtask

  // hold off until every row is taken and every span is back, then let the pipe settle
  task automatic drain();
    while (row_q.size() != 0 || rows_taken != rows_offered || span_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic box_cfg_t make_box(longint x, longint y, longint w, longint h,
                                        longint tl, longint tr, longint br, longint bl);
    box_cfg_t c;
    c.box_x          = COORD_WIDTH'(x);
    c.box_y          = COORD_WIDTH'(y);
    c.width          = DIM_WIDTH'(w);
    c.height         = DIM_WIDTH'(h);
    c.rad[CORNER_TL] = RAD_WIDTH'(tl);
    c.rad[CORNER_TR] = RAD_WIDTH'(tr);
    c.rad[CORNER_BR] = RAD_WIDTH'(br);
    c.rad[CORNER_BL] = RAD_WIDTH'(bl);
    return c;
  endfunction

  function automatic logic [DIM_WIDTH-1:0] pick_size();
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return DIM_WIDTH'($urandom());
      default: return DIM_WIDTH'($urandom_range(48, 1));
    endcase
  endfunction

  function automatic box_cfg_t random_config();
    box_cfg_t c;
    longint   half;
    c.box_x  = COORD_WIDTH'($urandom());
    c.box_y  = COORD_WIDTH'($urandom());
    c.width  = pick_size();
    c.height = pick_size();
    half = ((c.width < c.height) ? longint'(c.width) : longint'(c.height)) / 2;
    // radii most often up to just past the clamp, some zero, small or far beyond it
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(6))
        0:       c.rad[i] = '0;
        1:       c.rad[i] = RAD_WIDTH'($urandom());
        2, 3:    c.rad[i] = RAD_WIDTH'($urandom_range(20));
        default: c.rad[i] = RAD_WIDTH'($urandom_range(32'(half + 2)));
      endcase
    end
    return c;
  endfunction

  // rows aimed mostly at the box and its corner bands
  function automatic logic signed [COORD_WIDTH-1:0] pick_row(box_cfg_t c);
    longint by, h, band, y;
    by   = longint'(signed'(c.box_y));
    h    = longint'(c.height);
    band = longint'(c.rad[$urandom_range(3)]);
    if (band > h / 2) band = h / 2;
    case ($urandom_range(9))
      0, 1:    y = longint'($signed(COORD_WIDTH'($urandom())));
      2, 3:    y = by - 1 + longint'($urandom_range(32'(band + 1)));
      4, 5:    y = by + h - longint'($urandom_range(32'(band + 1)));
      default: y = by - 2 + longint'($urandom_range(32'(h + 3)));
    endcase
    if (y < COORD_MIN || y > COORD_MAX) y = by;
    return y[COORD_WIDTH-1:0];
  endfunction

  initial begin : stimulus
    box_cfg_t c;
    rst_n         = 1'b0;
    row_if.valid  = 1'b0;
    row_if.row_y  = '0;
    span_if.ready = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // registers at reset: empty box, every row misses
    begin_phase();
    row_q.push_back(COORD_WIDTH'(COORD_MIN));
    row_q.push_back(COORD_WIDTH'(0));
    row_q.push_back(COORD_WIDTH'(COORD_MAX));
    drain();

    // small box, one corner clamped hard, one square corner, rows around both bands
    c = make_box(-3, -5, 20, 16, 4, RAD_MAX, 0, 3);
    begin_phase();
    write_config(c);
    for (int y = -6; y <= 11; y++) begin
      if (y < 0 || y == 2 || y >= 6) row_q.push_back(COORD_WIDTH'(y));
    end
    drain();

    // largest box at the far corner of the plane, largest radii
    c = make_box(COORD_MAX, COORD_MIN, DIM_MAX, DIM_MAX, RAD_MAX, RAD_MAX, RAD_MAX, RAD_MAX);
    begin_phase();
    write_config(c);
    row_q.push_back(COORD_WIDTH'(COORD_MIN));
    row_q.push_back(COORD_WIDTH'(COORD_MIN + 1));
    row_q.push_back(COORD_WIDTH'(COORD_MIN + 4095));
    row_q.push_back(COORD_WIDTH'(COORD_MIN + DIM_MAX - 1));
    row_q.push_back(COORD_WIDTH'(COORD_MIN + DIM_MAX));
    drain();

    // one pixel wide box on the last row, radii clamp to zero
    c = make_box(COORD_MIN, COORD_MAX, 1, DIM_MAX, 7, 7, 7, 7);
    begin_phase();
    write_config(c);
    row_q.push_back(COORD_WIDTH'(COORD_MAX));
    row_q.push_back(COORD_WIDTH'(COORD_MAX - 1));
    drain();

    // zero width with a real height
    c = make_box(0, 0, 0, 5, 1, 1, 1, 1);
    begin_phase();
    write_config(c);
    row_q.push_back(COORD_WIDTH'(0));
    drain();

    // random boxes, each run to completion before the next setting
    repeat (RANDOM_PHASES) begin
      c = random_config();
      begin_phase();
      write_config(c);
      repeat (ROWS_PER_PHASE) row_q.push_back(pick_row(c));
      drain();
    end

    $display("%0d rows over %0d box settings, %0d of them with a covered span",
             rows_taken, settings_used, spans_covered);
    $display("%0d spans compared, %0d mismatches", spans_seen, mismatches);
    if (mismatches == 0 && span_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
